// ===== sv/hci_pkg.sv =====
// Shared types, constants and saturation helpers of the cubic Hermite interpolator.
// Used by every module of the block; depends on nothing.
`default_nettype none

package hci_pkg;

    localparam int NUM_DIMS = 8;
    localparam int DIM_W = (NUM_DIMS > 1) ? $clog2(NUM_DIMS) : 1;

    localparam logic [1:0] ST_INSIDE = 2'd0;
    localparam logic [1:0] ST_BELOW  = 2'd1;
    localparam logic [1:0] ST_ABOVE  = 2'd2;
    localparam logic [1:0] ST_FAIL   = 2'd3;

    localparam logic signed [18:0] P_MINUS_ONE = -19'sd65536;
    localparam logic signed [18:0] P_TWO       = 19'sd131072;

    typedef enum logic [1:0] {
        CMD_LOAD,
        CMD_FAIL,
        CMD_ORIGIN,
        CMD_EVAL
    } cmd_t;

    typedef struct packed {
        cmd_t              cmd;
        logic [2:0]        dim;
        logic signed [31:0] c0;
        logic signed [47:0] c1;
        logic signed [47:0] c2;
        logic signed [47:0] c3;
        logic signed [18:0] p;
        logic [1:0]        status;
        logic              with_der;
    } q_entry_t;

    typedef struct packed {
        logic [2:0]         out_dim;
        logic signed [31:0] value;
        logic signed [31:0] derivative;
        logic               value_valid;
        logic               derivative_valid;
        logic [1:0]         status;
        logic               last;
    } out_item_t;

    typedef enum logic [2:0] {
        F_IDLE,
        F_MUL0,
        F_MUL1,
        F_LOADFIN,
        F_CLASS,
        F_DIV,
        F_DIVFIN,
        F_PUSH
    } front_state_t;

    typedef enum logic [2:0] {
        B_IDLE,
        B_SETUP,
        B_MUL,
        B_ADD,
        B_DIVSET,
        B_DIV,
        B_EMIT
    } back_state_t;

    function automatic logic signed [47:0] sat48(input logic signed [51:0] v);
        if (v[51:47] == {5{v[47]}})
            return v[47:0];
        else if (v[51])
            return 48'sh8000_0000_0000;
        else
            return 48'sh7FFF_FFFF_FFFF;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [47:0] v);
        if (v[47:31] == {17{v[31]}})
            return v[31:0];
        else if (v[47])
            return 32'sh8000_0000;
        else
            return 32'sh7FFF_FFFF;
    endfunction

endpackage

`default_nettype wire

// ===== sv/hci_in_if.sv =====
// Input channel of the cubic Hermite interpolator: valid, ready and one input item.
// Depends on nothing.
`default_nettype none

interface hci_in_if;
    logic               valid;
    logic               ready;
    logic               mode;
    logic [2:0]         dim_index;
    logic signed [31:0] start_value;
    logic signed [31:0] value_change;
    logic signed [31:0] start_slope;
    logic signed [31:0] end_slope;
    logic signed [31:0] abscissa;

    modport source (
        output valid, mode, dim_index, start_value, value_change, start_slope,
               end_slope, abscissa,
        input  ready
    );

    modport sink (
        input  valid, mode, dim_index, start_value, value_change, start_slope,
               end_slope, abscissa,
        output ready
    );
endinterface

`default_nettype wire

// ===== sv/hci_out_if.sv =====
// Output channel of the cubic Hermite interpolator: valid, ready and one result item.
// Depends on nothing.
`default_nettype none

interface hci_out_if;
    logic               valid;
    logic               ready;
    logic [2:0]         out_dim;
    logic signed [31:0] value;
    logic signed [31:0] derivative;
    logic               value_valid;
    logic               derivative_valid;
    logic [1:0]         status;
    logic               last;

    modport source (
        output valid, out_dim, value, derivative, value_valid, derivative_valid,
               status, last,
        input  ready
    );

    modport sink (
        input  valid, out_dim, value, derivative, value_valid, derivative_valid,
               status, last,
        output ready
    );
endinterface

`default_nettype wire

// ===== sv/hermite_cubic_interp_vector_unit.sv =====
// Vector cubic Hermite interpolator over one segment, eight dimensions.
// Load items store one dimension's coefficients; evaluate items emit one result
// per dimension (or one failed result) on the output channel, the final one with last.
// Configuration: APB registers segment_origin at 0x0 and segment_step at 0x4. The
// user must write them only while the block is idle; the block does not enforce it.
// pready is always high. A load item passes through the front-end states F_MUL0 and
// F_MUL1, where one 32x32 multiplier forms both end slopes times the step.
// An evaluate item is classified in the front end, which for an abscissa within the
// checked range then divides out p, one quotient bit a cycle. The back end then runs
// per dimension five multiply-add steps on the shared Horner multiplier and a serial
// divide by the step when a derivative is produced, and only the value steps when not.
// A two-entry queue lets the front end accept and prepare later items while the
// back end works. A stalled receiver holds the output register, and the back end
// waits; the front end keeps going until the queue fills.
// Reset clears the loaded mask, so evaluations fail until every dimension is loaded.
// Depends on hci_pkg, hci_in_if, hci_out_if, hci_front, hci_queue and hci_back.
`default_nettype none

module hermite_cubic_interp_vector_unit
    import hci_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    hci_in_if.sink      in_ch,
    hci_out_if.source   out_ch,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic signed [31:0] origin_reg, step_reg;
    q_entry_t           push_data, pop_data;
    logic               push_valid, push_ready, pop_valid, pop_ready;

    assign pready = 1'b1;
    assign prdata = paddr[2] ? step_reg : origin_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            origin_reg <= 32'sd0;
            step_reg   <= 32'sd65536;
        end
        else if (psel && penable && pwrite)
        begin
            if (paddr[2])
                step_reg <= pwdata;
            else
                origin_reg <= pwdata;
        end
    end

    hci_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_ch      (in_ch),
        .origin     (origin_reg),
        .step       (step_reg),
        .push_data  (push_data),
        .push_valid (push_valid),
        .push_ready (push_ready)
    );

    hci_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_data  (push_data),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .pop_data   (pop_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready)
    );

    hci_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_data  (pop_data),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .step      (step_reg),
        .out_ch    (out_ch)
    );

endmodule

`default_nettype wire

// ===== sv/hci_front.sv =====
// Front end: accepts items, builds coefficients for loads, classifies evaluations
// and divides out p. Depends on hci_pkg and hci_in_if.
`default_nettype none

module hci_front
    import hci_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    hci_in_if.sink             in_ch,
    input  logic signed [31:0] origin,
    input  logic signed [31:0] step,
    output q_entry_t           push_data,
    output logic               push_valid,
    input  logic               push_ready
);

    front_state_t state_reg, state_next;

    logic [NUM_DIMS-1:0] mask_reg;
    logic [2:0]          dim_reg;
    logic signed [31:0]  y0_reg, dy_reg, s0_reg, s1_reg, x_reg;
    logic signed [63:0]  prod_reg;
    logic signed [47:0]  m0_reg;
    q_entry_t            ent_reg;
    logic [49:0]         rem_reg, dsr_reg;
    logic [17:0]         q_reg;
    logic [4:0]          cnt_reg;
    logic                pneg_reg;
    logic [1:0]          status_reg;

    logic               accept, load_ok;
    logic signed [63:0] prod_mul;
    logic signed [47:0] m1;
    logic signed [51:0] dy_w, m0_w, m1_w;
    logic signed [32:0] d;
    logic signed [33:0] ds, hs, nh, h2;
    logic               hpos, lt_m1, gt_2, neg, le1;
    logic [32:0]        absd;
    logic [31:0]        absh;
    q_entry_t           load_ent, class_ent;

    assign accept  = in_ch.valid && in_ch.ready;
    assign load_ok = 32'(in_ch.dim_index) < NUM_DIMS;

    assign prod_mul = (state_reg == F_MUL0) ? s0_reg * step : s1_reg * step;
    assign m1       = prod_reg[63:16];
    assign dy_w     = 52'(dy_reg);
    assign m0_w     = 52'(m0_reg);
    assign m1_w     = 52'(m1);

    assign d     = 33'(x_reg) - 33'(origin);
    assign ds    = 34'(d);
    assign hs    = 34'(step);
    assign nh    = -hs;
    assign h2    = hs + hs;
    assign hpos  = !step[31];
    assign lt_m1 = hpos ? (ds < nh) : (ds > nh);
    assign gt_2  = hpos ? (ds > h2) : (ds < h2);
    assign neg   = hpos ? (ds < 34'sd0) : (ds > 34'sd0);
    assign le1   = hpos ? (ds <= hs) : (ds >= hs);
    assign absd  = d[32] ? 33'(-d) : 33'(d);
    assign absh  = step[31] ? 32'(-step) : 32'(step);

    assign in_ch.ready = (state_reg == F_IDLE);
    assign push_valid  = (state_reg == F_PUSH);
    assign push_data   = ent_reg;

    always_comb
    begin
        load_ent     = '0;
        load_ent.cmd = CMD_LOAD;
        load_ent.dim = dim_reg;
        load_ent.c0  = y0_reg;
        load_ent.c1  = m0_reg;
        load_ent.c2  = sat48(dy_w + dy_w + dy_w - (m0_w + m0_w) - m1_w);
        load_ent.c3  = sat48(m0_w + m1_w - (dy_w + dy_w));

        class_ent = '0;
        if (!(&mask_reg))
            class_ent.cmd = CMD_FAIL;
        else if (d == 33'sd0)
            class_ent.cmd = CMD_ORIGIN;
        else if (step == 32'sd0)
            class_ent.cmd = CMD_FAIL;
        else if (lt_m1 || gt_2)
        begin
            class_ent.cmd    = CMD_EVAL;
            class_ent.p      = lt_m1 ? P_MINUS_ONE : P_TWO;
            class_ent.status = ST_FAIL;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            F_IDLE:
            begin
                if (accept)
                begin
                    if (in_ch.mode)
                        state_next = F_CLASS;
                    else if (load_ok)
                        state_next = F_MUL0;
                end
            end
            F_MUL0:    state_next = F_MUL1;
            F_MUL1:    state_next = F_LOADFIN;
            F_LOADFIN: state_next = F_PUSH;
            F_CLASS:
            begin
                if ((&mask_reg) && (d != 33'sd0) && (step != 32'sd0) && !lt_m1 && !gt_2)
                    state_next = F_DIV;
                else
                    state_next = F_PUSH;
            end
            F_DIV:
            begin
                if (cnt_reg == 5'd0)
                    state_next = F_DIVFIN;
            end
            F_DIVFIN:  state_next = F_PUSH;
            F_PUSH:
            begin
                if (push_ready)
                    state_next = F_IDLE;
            end
            default:   state_next = F_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg <= '0;
        end
        else if (accept && !in_ch.mode)
        begin
            for (int i = 0; i < NUM_DIMS; i++)
            begin
                if (32'(in_ch.dim_index) == i)
                    mask_reg[i] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            F_IDLE:
            begin
                if (accept)
                begin
                    dim_reg <= in_ch.dim_index;
                    y0_reg  <= in_ch.start_value;
                    dy_reg  <= in_ch.value_change;
                    s0_reg  <= in_ch.start_slope;
                    s1_reg  <= in_ch.end_slope;
                    x_reg   <= in_ch.abscissa;
                end
            end
            F_MUL0:
            begin
                prod_reg <= prod_mul;
            end
            F_MUL1:
            begin
                m0_reg   <= prod_reg[63:16];
                prod_reg <= prod_mul;
            end
            F_LOADFIN:
            begin
                ent_reg <= load_ent;
            end
            F_CLASS:
            begin
                ent_reg    <= class_ent;
                rem_reg    <= 50'({absd, 16'b0});
                dsr_reg    <= 50'({absh, 17'b0});
                q_reg      <= '0;
                cnt_reg    <= 5'd17;
                pneg_reg   <= d[32] ^ step[31];
                status_reg <= neg ? ST_BELOW : (le1 ? ST_INSIDE : ST_ABOVE);
            end
            F_DIV:
            begin
                if (rem_reg >= dsr_reg)
                begin
                    rem_reg <= rem_reg - dsr_reg;
                    q_reg   <= {q_reg[16:0], 1'b1};
                end
                else
                begin
                    q_reg <= {q_reg[16:0], 1'b0};
                end
                dsr_reg <= dsr_reg >> 1;
                cnt_reg <= cnt_reg - 5'd1;
            end
            F_DIVFIN:
            begin
                ent_reg.cmd      <= CMD_EVAL;
                ent_reg.p        <= pneg_reg ? -$signed({1'b0, q_reg}) : $signed({1'b0, q_reg});
                ent_reg.status   <= status_reg;
                ent_reg.with_der <= 1'b1;
            end
            default:
            begin
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== sv/hci_queue.sv =====
// Two-entry queue that decouples the front end from the evaluation back end.
// Depends on hci_pkg.
`default_nettype none

module hci_queue
    import hci_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  q_entry_t push_data,
    input  logic     push_valid,
    output logic     push_ready,
    output q_entry_t pop_data,
    output logic     pop_valid,
    input  logic     pop_ready
);

    q_entry_t   ent_reg [2];
    logic       wr_reg, rd_reg;
    logic [1:0] cnt_reg;
    logic       do_push, do_pop;

    assign push_ready = (cnt_reg != 2'd2);
    assign pop_valid  = (cnt_reg != 2'd0);
    assign pop_data   = ent_reg[rd_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= 1'b0;
            rd_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (do_push)
                wr_reg <= !wr_reg;
            if (do_pop)
                rd_reg <= !rd_reg;
            if (do_push && !do_pop)
                cnt_reg <= cnt_reg + 2'd1;
            else if (do_pop && !do_push)
                cnt_reg <= cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            ent_reg[wr_reg] <= push_data;
    end

endmodule

`default_nettype wire

// ===== sv/hci_back.sv =====
// Back end: holds the coefficient table and walks each dimension through a shared
// Horner multiplier and a serial divider. Depends on hci_pkg and hci_out_if.
`default_nettype none

module hci_back
    import hci_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  q_entry_t           pop_data,
    input  logic               pop_valid,
    output logic               pop_ready,
    input  logic signed [31:0] step,
    hci_out_if.source          out_ch
);

    localparam logic [2:0] STP_VALUE_END = 3'd2;
    localparam logic [2:0] STP_DER_END   = 3'd4;

    back_state_t state_reg, state_next;

    logic signed [31:0] c0_mem [NUM_DIMS];
    logic signed [47:0] c1_mem [NUM_DIMS];
    logic signed [47:0] c2_mem [NUM_DIMS];
    logic signed [47:0] c3_mem [NUM_DIMS];

    q_entry_t           ent_reg;
    logic [DIM_W-1:0]   cnt_reg;
    logic [2:0]         stp_reg;
    logic signed [47:0] accv_reg, accu_reg;
    logic signed [66:0] prod_reg;
    logic [63:0]        rem_reg, dsr_reg;
    logic [31:0]        q_reg;
    logic [4:0]         dcnt_reg;
    logic               ovf_reg, dneg_reg;
    out_item_t          o_reg;
    logic               ovalid_reg;

    logic               emit_go, last_dim;
    logic signed [47:0] mul_a;
    logic signed [66:0] prod_mul;
    logic signed [50:0] prod_sh;
    logic signed [51:0] addend, sum;
    logic signed [47:0] sum_sat;
    logic signed [63:0] num;
    logic [63:0]        absn;
    logic [31:0]        absh;
    logic signed [31:0] der;
    out_item_t          o_next;

    assign pop_ready = (state_reg == B_IDLE);
    assign emit_go   = (state_reg == B_EMIT) && (!ovalid_reg || out_ch.ready);
    assign last_dim  = (cnt_reg == DIM_W'(NUM_DIMS - 1));

    assign mul_a    = (stp_reg <= STP_VALUE_END) ? accv_reg : accu_reg;
    assign prod_mul = mul_a * ent_reg.p;
    assign prod_sh  = prod_reg[66:16];
    assign sum      = 52'(prod_sh) + addend;
    assign sum_sat  = sat48(sum);

    assign num  = {accu_reg, 16'b0};
    assign absn = accu_reg[47] ? 64'(-num) : 64'(num);
    assign absh = step[31] ? 32'(-step) : 32'(step);

    always_comb
    begin
        case (stp_reg)
            3'd0:    addend = 52'(c2_mem[cnt_reg]);
            3'd1:    addend = 52'(c1_mem[cnt_reg]);
            3'd2:    addend = 52'(c0_mem[cnt_reg]);
            3'd3:    addend = 52'(c2_mem[cnt_reg]) + 52'(c2_mem[cnt_reg]);
            default: addend = 52'(c1_mem[cnt_reg]);
        endcase
    end

    always_comb
    begin
        if (ovf_reg)
            der = dneg_reg ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        else if (!dneg_reg)
            der = q_reg[31] ? 32'sh7FFF_FFFF : $signed(q_reg);
        else if (q_reg[31] && (|q_reg[30:0]))
            der = 32'sh8000_0000;
        else
            der = -$signed(q_reg);
    end

    always_comb
    begin
        o_next = '0;
        unique case (ent_reg.cmd)
            CMD_ORIGIN:
            begin
                o_next.out_dim     = 3'(cnt_reg);
                o_next.value       = c0_mem[cnt_reg];
                o_next.value_valid = 1'b1;
                o_next.status      = ST_INSIDE;
                o_next.last        = last_dim;
            end
            CMD_EVAL:
            begin
                o_next.out_dim          = 3'(cnt_reg);
                o_next.value            = sat32(accv_reg);
                o_next.derivative       = ent_reg.with_der ? der : 32'sd0;
                o_next.value_valid      = 1'b1;
                o_next.derivative_valid = ent_reg.with_der;
                o_next.status           = ent_reg.status;
                o_next.last             = last_dim;
            end
            default:
            begin
                o_next.status = ST_FAIL;
                o_next.last   = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= B_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            B_IDLE:
            begin
                if (pop_valid)
                begin
                    if (pop_data.cmd == CMD_EVAL)
                        state_next = B_SETUP;
                    else if (pop_data.cmd != CMD_LOAD)
                        state_next = B_EMIT;
                end
            end
            B_SETUP: state_next = B_MUL;
            B_MUL:   state_next = B_ADD;
            B_ADD:
            begin
                if (stp_reg == STP_VALUE_END && !ent_reg.with_der)
                    state_next = B_EMIT;
                else if (stp_reg == STP_DER_END)
                    state_next = B_DIVSET;
                else
                    state_next = B_MUL;
            end
            B_DIVSET: state_next = B_DIV;
            B_DIV:
            begin
                if (dcnt_reg == 5'd0)
                    state_next = B_EMIT;
            end
            B_EMIT:
            begin
                if (emit_go)
                begin
                    if (ent_reg.cmd == CMD_FAIL || last_dim)
                        state_next = B_IDLE;
                    else if (ent_reg.cmd == CMD_EVAL)
                        state_next = B_SETUP;
                end
            end
            default: state_next = B_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ovalid_reg <= 1'b0;
            cnt_reg    <= '0;
            stp_reg    <= '0;
        end
        else
        begin
            if (emit_go)
                ovalid_reg <= 1'b1;
            else if (out_ch.ready)
                ovalid_reg <= 1'b0;

            if (state_reg == B_IDLE)
                cnt_reg <= '0;
            else if (emit_go && !last_dim)
                cnt_reg <= cnt_reg + DIM_W'(1);

            if (state_reg == B_SETUP)
                stp_reg <= '0;
            else if (state_reg == B_ADD)
                stp_reg <= stp_reg + 3'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == B_IDLE && pop_valid)
        begin
            ent_reg <= pop_data;
            if (pop_data.cmd == CMD_LOAD)
            begin
                for (int i = 0; i < NUM_DIMS; i++)
                begin
                    if (32'(pop_data.dim) == i)
                    begin
                        c0_mem[i] <= pop_data.c0;
                        c1_mem[i] <= pop_data.c1;
                        c2_mem[i] <= pop_data.c2;
                        c3_mem[i] <= pop_data.c3;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            B_SETUP:
            begin
                accv_reg <= c3_mem[cnt_reg];
                accu_reg <= sat48(52'(c3_mem[cnt_reg]) + 52'(c3_mem[cnt_reg])
                                  + 52'(c3_mem[cnt_reg]));
            end
            B_MUL:
            begin
                prod_reg <= prod_mul;
            end
            B_ADD:
            begin
                if (stp_reg <= STP_VALUE_END)
                    accv_reg <= sum_sat;
                else
                    accu_reg <= sum_sat;
            end
            B_DIVSET:
            begin
                rem_reg  <= absn;
                dsr_reg  <= {1'b0, absh, 31'b0};
                ovf_reg  <= (absn >= {absh, 32'b0});
                dneg_reg <= accu_reg[47] ^ step[31];
                q_reg    <= '0;
                dcnt_reg <= 5'd31;
            end
            B_DIV:
            begin
                if (rem_reg >= dsr_reg)
                begin
                    rem_reg <= rem_reg - dsr_reg;
                    q_reg   <= {q_reg[30:0], 1'b1};
                end
                else
                begin
                    q_reg <= {q_reg[30:0], 1'b0};
                end
                dsr_reg  <= dsr_reg >> 1;
                dcnt_reg <= dcnt_reg - 5'd1;
            end
            default:
            begin
            end
        endcase
        if (emit_go)
            o_reg <= o_next;
    end

    assign out_ch.valid            = ovalid_reg;
    assign out_ch.out_dim          = o_reg.out_dim;
    assign out_ch.value            = o_reg.value;
    assign out_ch.derivative       = o_reg.derivative;
    assign out_ch.value_valid      = o_reg.value_valid;
    assign out_ch.derivative_valid = o_reg.derivative_valid;
    assign out_ch.status           = o_reg.status;
    assign out_ch.last             = o_reg.last;

    a_fail_alone: assert property (@(posedge clk) disable iff (!rst_n)
        ovalid_reg && !o_reg.value_valid |-> o_reg.status == ST_FAIL && o_reg.last)
        else $error("A result without a value must be a single failed result.");

    a_der_needs_val: assert property (@(posedge clk) disable iff (!rst_n)
        ovalid_reg && o_reg.derivative_valid
            |-> o_reg.value_valid && o_reg.status != ST_FAIL)
        else $error("A derivative came with a failed status or without a value.");

    a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == B_DIV && dcnt_reg == 5'd0 |=> state_reg == B_EMIT)
        else $error("The divider finished without moving on to emit a result.");

    a_no_pop_busy: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == B_EMIT && emit_go && !last_dim && ent_reg.cmd == CMD_ORIGIN
            |=> state_reg == B_EMIT)
        else $error("An origin evaluation stopped before its final dimension.");

endmodule

`default_nettype wire
